[rtl/tsc_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tsc_pkg
// Shared types and constants for the Taylor-series sine/cosine pipeline.
// ---------------------------------------------------------------------------
package tsc_pkg;

    // Width of the signed angle input and of the signed result.
    localparam int ANGLE_W = 32;
    localparam int VALUE_W = 32;

    // Term magnitudes, reciprocal constants and the running sum.
    localparam int TERM_W  = 62;
    localparam int RECIP_W = 48;
    localparam int ACC_W   = 64;

    // Split points for the partial products of the wide multiplies.
    localparam int M_LO_W = 31;
    localparam int M_HI_W = TERM_W - M_LO_W;
    localparam int R_LO_W = 24;
    localparam int R_HI_W = RECIP_W - R_LO_W;

    // A term magnitude saturates here.
    localparam logic [TERM_W-1:0] TERM_CAP = {TERM_W{1'b1}};

    // The running sum is clamped to plus or minus this value.
    localparam logic signed [ACC_W-1:0] ACC_CAP = 64'sh4000_0000_0000_0000;

    // Output clamp bounds.
    localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] OUT_MIN = -64'sh0000_0000_8000_0000;

    // Mode codes.
    localparam logic MODE_COS = 1'b0;
    localparam logic MODE_SIN = 1'b1;

    // Control that travels with each transaction through the pipeline.
    typedef struct packed {
        logic valid;
        logic mode;
        logic sign;
    } tsc_ctrl_t;

endpackage : tsc_pkg
`default_nettype wire

[rtl/tsc_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tsc_front
// Front end: takes the angle magnitude, squares it, rounds x squared and
// forms the first term of the series.
// ---------------------------------------------------------------------------
module tsc_front #(
    parameter int FRAC_BITS = 28,
    parameter int X2_W      = 35
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_mode,
    input  wire logic signed [tsc_pkg::ANGLE_W-1:0] in_angle,
    output tsc_pkg::tsc_ctrl_t                      ctrl,
    output logic [tsc_pkg::TERM_W-1:0]              m,
    output logic [X2_W-1:0]                         x2,
    output logic signed [tsc_pkg::ACC_W-1:0]        acc
);

    localparam int SQ_W = 2 * tsc_pkg::ANGLE_W;

    tsc_pkg::tsc_ctrl_t                ctrl1_reg, ctrl2_reg, ctrl3_reg;
    logic [tsc_pkg::ANGLE_W-1:0]       xmag_reg;
    logic [SQ_W-1:0]                   sq_reg;
    logic [tsc_pkg::TERM_W-1:0]        m2_reg, m3_reg;
    logic [X2_W-1:0]                   x2_reg;
    logic signed [tsc_pkg::ACC_W-1:0]  acc_reg;

    logic [tsc_pkg::ANGLE_W-1:0]       xmag_next;
    logic [SQ_W-1:0]                   sq_rnd;
    logic [tsc_pkg::TERM_W-1:0]        m_first;

    // Magnitude of the angle; the most negative angle gives 2^31 unsigned.
    always_comb
    begin
        xmag_next = in_angle[tsc_pkg::ANGLE_W-1] ? (~in_angle + 1'b1) : in_angle;
    end

    // First term: x for sine, one for cosine.
    always_comb
    begin
        if (ctrl1_reg.mode == tsc_pkg::MODE_SIN)
            m_first = tsc_pkg::TERM_W'(xmag_reg);
        else
            m_first = tsc_pkg::TERM_W'(1) << FRAC_BITS;
    end

    // Rounded x squared; the square is at most 2^62 so the sum cannot wrap.
    always_comb
    begin
        sq_rnd = sq_reg + (SQ_W'(1) << (FRAC_BITS - 1));
    end

    // Control fields and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
        end
        else
        begin
            ctrl1_reg.valid <= in_valid;
            ctrl1_reg.mode  <= in_mode;
            ctrl1_reg.sign  <= in_angle[tsc_pkg::ANGLE_W-1];

            ctrl2_reg.valid <= ctrl1_reg.valid;
            ctrl2_reg.mode  <= ctrl1_reg.mode;
            ctrl2_reg.sign  <= (ctrl1_reg.mode == tsc_pkg::MODE_SIN) ? ctrl1_reg.sign
                                                                     : 1'b0;

            ctrl3_reg.valid <= ctrl2_reg.valid;
            ctrl3_reg.mode  <= ctrl2_reg.mode;
            ctrl3_reg.sign  <= ctrl2_reg.sign;
        end
    end

    // Data path stages.
    always_ff @(posedge clk)
    begin
        xmag_reg       <= xmag_next;

        sq_reg         <= SQ_W'(xmag_reg) * SQ_W'(xmag_reg);
        m2_reg         <= m_first;

        x2_reg         <= X2_W'(sq_rnd >> FRAC_BITS);
        m3_reg         <= m2_reg;
        acc_reg        <= ctrl2_reg.sign ? -$signed({2'b00, m2_reg})
                                         :  $signed({2'b00, m2_reg});
    end

    assign ctrl = ctrl3_reg;
    assign m    = m3_reg;
    assign x2   = x2_reg;
    assign acc  = acc_reg;

endmodule : tsc_front
`default_nettype wire

[rtl/tsc_term.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// tsc_term
// One series term: multiplies the previous term by x squared and by the
// rounded reciprocal of the next two factorial factors, then adds the
// signed term into the running sum. Five register stages.
// ---------------------------------------------------------------------------
module tsc_term #(
    parameter int FRAC_BITS = 28,
    parameter int X2_W      = 35,
    parameter int IDX       = 1
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  tsc_pkg::tsc_ctrl_t                      ctrl_in,
    input  wire logic [tsc_pkg::TERM_W-1:0]         m_in,
    input  wire logic [X2_W-1:0]                    x2_in,
    input  wire logic signed [tsc_pkg::ACC_W-1:0]   acc_in,
    output tsc_pkg::tsc_ctrl_t                      ctrl_out,
    output logic [tsc_pkg::TERM_W-1:0]              m_out,
    output logic [X2_W-1:0]                         x2_out,
    output logic signed [tsc_pkg::ACC_W-1:0]        acc_out
);

    localparam int H    = (X2_W + 1) / 2;
    localparam int XH_W = X2_W - H;
    localparam int P1_W = tsc_pkg::M_LO_W + H;
    localparam int S1_W = tsc_pkg::TERM_W + X2_W + 1;
    localparam int P2_W = tsc_pkg::M_LO_W + tsc_pkg::R_LO_W;
    localparam int S2_W = tsc_pkg::TERM_W + tsc_pkg::RECIP_W + 1;

    // Reciprocals of the factor pairs for this term, rounded to nearest.
    localparam logic [63:0] K_COS  = 64'((2 * IDX - 1) * (2 * IDX));
    localparam logic [63:0] K_SIN  = 64'((2 * IDX) * (2 * IDX + 1));
    localparam logic [63:0] ONE_R  = 64'd1 << tsc_pkg::RECIP_W;
    localparam logic [63:0] RC_COS = (ONE_R + (K_COS >> 1)) / K_COS;
    localparam logic [63:0] RC_SIN = (ONE_R + (K_SIN >> 1)) / K_SIN;

    tsc_pkg::tsc_ctrl_t ctrl1_reg, ctrl2_reg, ctrl3_reg, ctrl4_reg, ctrl5_reg;
    logic [X2_W-1:0]   x2_1_reg, x2_2_reg, x2_3_reg, x2_4_reg, x2_5_reg;
    logic signed [tsc_pkg::ACC_W-1:0] acc1_reg, acc2_reg, acc3_reg, acc4_reg, acc5_reg;

    logic [P1_W-1:0]   pa_ll_reg, pa_lh_reg, pa_hl_reg, pa_hh_reg;
    logic [P1_W-1:0]   pa_ll, pa_lh, pa_hl, pa_hh;
    logic [tsc_pkg::TERM_W-1:0] m2_reg, m2_next;
    logic [P2_W-1:0]   pb_ll_reg, pb_lh_reg, pb_hl_reg, pb_hh_reg;
    logic [P2_W-1:0]   pb_ll, pb_lh, pb_hl, pb_hh;
    logic [tsc_pkg::TERM_W-1:0] m4_reg, m4_next;
    logic signed [tsc_pkg::ACC_W-1:0] acc5_next;

    logic [tsc_pkg::RECIP_W-1:0] recip;
    logic [S1_W-1:0]   sum1, rsh1;
    logic [S2_W-1:0]   sum2, rsh2;
    logic [tsc_pkg::M_LO_W-1:0] ma_lo, mb_lo;
    logic [tsc_pkg::M_HI_W-1:0] ma_hi, mb_hi;
    logic [H-1:0]      x_lo;
    logic [XH_W-1:0]   x_hi;
    logic signed [tsc_pkg::ACC_W-1:0] term_s, acc_sum;

    // Stage 1: partial products of the term and x squared.
    always_comb
    begin
        ma_lo = m_in[tsc_pkg::M_LO_W-1:0];
        ma_hi = m_in[tsc_pkg::TERM_W-1:tsc_pkg::M_LO_W];
        x_lo  = x2_in[H-1:0];
        x_hi  = x2_in[X2_W-1:H];
        pa_ll = P1_W'(ma_lo) * P1_W'(x_lo);
        pa_lh = P1_W'(ma_lo) * P1_W'(x_hi);
        pa_hl = P1_W'(ma_hi) * P1_W'(x_lo);
        pa_hh = P1_W'(ma_hi) * P1_W'(x_hi);
    end

    // Stage 2: combine, round and saturate.
    always_comb
    begin
        sum1 = S1_W'(pa_ll_reg)
             + (S1_W'(pa_lh_reg) << H)
             + (S1_W'(pa_hl_reg) << tsc_pkg::M_LO_W)
             + (S1_W'(pa_hh_reg) << (tsc_pkg::M_LO_W + H))
             + (S1_W'(1) << (FRAC_BITS - 1));
        rsh1 = sum1 >> FRAC_BITS;
        if (rsh1 > S1_W'(tsc_pkg::TERM_CAP))
            m2_next = tsc_pkg::TERM_CAP;
        else
            m2_next = rsh1[tsc_pkg::TERM_W-1:0];
    end

    // Stage 3: partial products with the reciprocal for the mode.
    always_comb
    begin
        recip = (ctrl2_reg.mode == tsc_pkg::MODE_SIN) ? RC_SIN[tsc_pkg::RECIP_W-1:0]
                                                      : RC_COS[tsc_pkg::RECIP_W-1:0];
        mb_lo = m2_reg[tsc_pkg::M_LO_W-1:0];
        mb_hi = m2_reg[tsc_pkg::TERM_W-1:tsc_pkg::M_LO_W];
        pb_ll = P2_W'(mb_lo) * P2_W'(recip[tsc_pkg::R_LO_W-1:0]);
        pb_lh = P2_W'(mb_lo) * P2_W'(recip[tsc_pkg::RECIP_W-1:tsc_pkg::R_LO_W]);
        pb_hl = P2_W'(mb_hi) * P2_W'(recip[tsc_pkg::R_LO_W-1:0]);
        pb_hh = P2_W'(mb_hi) * P2_W'(recip[tsc_pkg::RECIP_W-1:tsc_pkg::R_LO_W]);
    end

    // Stage 4: combine, round and saturate.
    always_comb
    begin
        sum2 = S2_W'(pb_ll_reg)
             + (S2_W'(pb_lh_reg) << tsc_pkg::R_LO_W)
             + (S2_W'(pb_hl_reg) << tsc_pkg::M_LO_W)
             + (S2_W'(pb_hh_reg) << (tsc_pkg::M_LO_W + tsc_pkg::R_LO_W))
             + (S2_W'(1) << (tsc_pkg::RECIP_W - 1));
        rsh2 = sum2 >> tsc_pkg::RECIP_W;
        if (rsh2 > S2_W'(tsc_pkg::TERM_CAP))
            m4_next = tsc_pkg::TERM_CAP;
        else
            m4_next = rsh2[tsc_pkg::TERM_W-1:0];
    end

    // Stage 5: add the term with its flipped sign and clamp the sum.
    always_comb
    begin
        term_s  = $signed({2'b00, m4_reg});
        acc_sum = ctrl4_reg.sign ? (acc4_reg + term_s) : (acc4_reg - term_s);
        if (acc_sum > tsc_pkg::ACC_CAP)
            acc5_next = tsc_pkg::ACC_CAP;
        else if (acc_sum < -tsc_pkg::ACC_CAP)
            acc5_next = -tsc_pkg::ACC_CAP;
        else
            acc5_next = acc_sum;
    end

    // Control fields and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
            ctrl4_reg <= '0;
            ctrl5_reg <= '0;
        end
        else
        begin
            ctrl1_reg       <= ctrl_in;
            ctrl2_reg       <= ctrl1_reg;
            ctrl3_reg       <= ctrl2_reg;
            ctrl4_reg       <= ctrl3_reg;
            ctrl5_reg.valid <= ctrl4_reg.valid;
            ctrl5_reg.mode  <= ctrl4_reg.mode;
            ctrl5_reg.sign  <= ~ctrl4_reg.sign;
        end
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        x2_1_reg       <= x2_in;
        acc1_reg       <= acc_in;
        pa_ll_reg      <= pa_ll;
        pa_lh_reg      <= pa_lh;
        pa_hl_reg      <= pa_hl;
        pa_hh_reg      <= pa_hh;

        x2_2_reg       <= x2_1_reg;
        acc2_reg       <= acc1_reg;
        m2_reg         <= m2_next;

        x2_3_reg       <= x2_2_reg;
        acc3_reg       <= acc2_reg;
        pb_ll_reg      <= pb_ll;
        pb_lh_reg      <= pb_lh;
        pb_hl_reg      <= pb_hl;
        pb_hh_reg      <= pb_hh;

        x2_4_reg       <= x2_3_reg;
        acc4_reg       <= acc3_reg;
        m4_reg         <= m4_next;

        x2_5_reg       <= x2_4_reg;
        acc5_reg       <= acc5_next;
    end

    // The term itself goes on unchanged from stage 4 to the next term.
    logic [tsc_pkg::TERM_W-1:0] m5_reg;

    always_ff @(posedge clk)
    begin
        m5_reg <= m4_reg;
    end

    assign ctrl_out = ctrl5_reg;
    assign m_out    = m5_reg;
    assign x2_out   = x2_5_reg;
    assign acc_out  = acc5_reg;

endmodule : tsc_term
`default_nettype wire

[rtl/taylor_sine_cosine_unit.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// taylor_sine_cosine_unit
// Fixed-point sine or cosine by an alternating Taylor series, fully pipelined.
// ---------------------------------------------------------------------------
// A transaction is taken on every cycle that start is high; busy is always
// low. The result appears on value with done high for one cycle, in order,
// after the front-end stages, the series-term sections and the result register.
// Each series term has five stages: two split multiplies, each with a
// partial-product stage and a round/saturate stage, and the accumulate.
// The receiver cannot stall the pipeline.
// ---------------------------------------------------------------------------
module taylor_sine_cosine_unit #(
    parameter int TERMS     = 15,
    parameter int FRAC_BITS = 28
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                mode,
    input  wire logic signed [tsc_pkg::ANGLE_W-1:0]  angle,
    output logic                                     done,
    output logic signed [tsc_pkg::VALUE_W-1:0]       value
);

    localparam int X2_W = 63 - FRAC_BITS;

    tsc_pkg::tsc_ctrl_t                ctrl_c [TERMS];
    logic [tsc_pkg::TERM_W-1:0]        m_c    [TERMS];
    logic [X2_W-1:0]                   x2_c   [TERMS];
    logic signed [tsc_pkg::ACC_W-1:0]  acc_c  [TERMS];

    logic                              done_reg;
    logic signed [tsc_pkg::VALUE_W-1:0] value_reg, value_next;

    // Angle magnitude, x squared and the first term.
    tsc_front #(
        .FRAC_BITS (FRAC_BITS),
        .X2_W      (X2_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start),
        .in_mode  (mode),
        .in_angle (angle),
        .ctrl     (ctrl_c[0]),
        .m        (m_c[0]),
        .x2       (x2_c[0]),
        .acc      (acc_c[0])
    );

    // One pipeline section per remaining term.
    for (genvar i = 1; i < TERMS; i++)
    begin : g_term
        tsc_term #(
            .FRAC_BITS (FRAC_BITS),
            .X2_W      (X2_W),
            .IDX       (i)
        ) u_term (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl_in  (ctrl_c[i-1]),
            .m_in     (m_c[i-1]),
            .x2_in    (x2_c[i-1]),
            .acc_in   (acc_c[i-1]),
            .ctrl_out (ctrl_c[i]),
            .m_out    (m_c[i]),
            .x2_out   (x2_c[i]),
            .acc_out  (acc_c[i])
        );
    end

    // Clamp the sum to the 32-bit result range.
    always_comb
    begin
        if (acc_c[TERMS-1] > tsc_pkg::OUT_MAX)
            value_next = tsc_pkg::VALUE_W'(tsc_pkg::OUT_MAX);
        else if (acc_c[TERMS-1] < tsc_pkg::OUT_MIN)
            value_next = tsc_pkg::VALUE_W'(tsc_pkg::OUT_MIN);
        else
            value_next = acc_c[TERMS-1][tsc_pkg::VALUE_W-1:0];
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctrl_c[TERMS-1].valid;
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign busy  = 1'b0;
    assign done  = done_reg;
    assign value = value_reg;

endmodule : taylor_sine_cosine_unit
`default_nettype wire

[dv/tsc_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tsc_checker
// Watches the command and result ports of the sine/cosine unit, computes the
// series sum for every accepted transaction and compares each result with
// the oldest expected value.
// ---------------------------------------------------------------------------
module tsc_checker #(
    parameter int TERMS     = 15,
    parameter int FRAC_BITS = 28
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    input  wire logic                               busy,
    input  wire logic                               mode,
    input  wire logic signed [tsc_pkg::ANGLE_W-1:0] angle,
    input  wire logic                               done,
    input  wire logic signed [tsc_pkg::VALUE_W-1:0] value,
    output int                                      fail_count,
    output int                                      pending
);

    localparam int RECIP_BITS = 48;

    logic signed [tsc_pkg::VALUE_W-1:0] expected_values[$];

    // Rounded magnitude product, ties away from zero, capped at the term limit.
    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        begin
            p = ({64'd0, a} * {64'd0, b} + (128'd1 << (sh - 1))) >> sh;
            if (p > {66'd0, tsc_pkg::TERM_CAP})
                p = {66'd0, tsc_pkg::TERM_CAP};
            return p[63:0];
        end
    endfunction

    // Series sum of cosine or sine for one angle.
    function automatic logic signed [tsc_pkg::VALUE_W-1:0] series_sum(
        logic md, logic signed [tsc_pkg::ANGLE_W-1:0] x);
        logic        neg;
        logic        sgn;
        logic [63:0] xmag;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] k;
        logic [63:0] recip;
        logic signed [63:0] acc;
        begin
            neg  = x[tsc_pkg::ANGLE_W-1];
            xmag = neg ? (64'd1 << 32) - {32'd0, x} : {32'd0, x};
            x2   = scaled_product(xmag, xmag, FRAC_BITS);
            if (md == tsc_pkg::MODE_SIN)
            begin
                term = xmag;
                sgn  = neg;
            end
            else
            begin
                term = 64'd1 << FRAC_BITS;
                sgn  = 1'b0;
            end
            acc = sgn ? -$signed(term) : $signed(term);
            for (int i = 1; i < TERMS; i++)
            begin
                k = (md == tsc_pkg::MODE_SIN) ? 64'(2 * i) * 64'(2 * i + 1)
                                              : 64'(2 * i - 1) * 64'(2 * i);
                recip = ((64'd1 << RECIP_BITS) + (k >> 1)) / k;
                term  = scaled_product(term, x2, FRAC_BITS);
                term  = scaled_product(term, recip, RECIP_BITS);
                sgn   = !sgn;
                acc   = sgn ? acc - $signed(term) : acc + $signed(term);
                if (acc > tsc_pkg::ACC_CAP)
                    acc = tsc_pkg::ACC_CAP;
                if (acc < -tsc_pkg::ACC_CAP)
                    acc = -tsc_pkg::ACC_CAP;
            end
            if (acc > tsc_pkg::OUT_MAX)
                acc = tsc_pkg::OUT_MAX;
            if (acc < tsc_pkg::OUT_MIN)
                acc = tsc_pkg::OUT_MIN;
            return acc[tsc_pkg::VALUE_W-1:0];
        end
    endfunction

    task automatic report_mismatch(string msg);
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
            fail_count++;
        end
    endtask

    initial fail_count = 0;
    assign pending = expected_values.size();

    // Predict on each accepted command, compare on each result strobe.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_values.size() == 0)
                    report_mismatch($sformatf("result %h with nothing expected", value));
                else
                begin
                    logic signed [tsc_pkg::VALUE_W-1:0] want;
                    want = expected_values.pop_front();
                    if (value !== want)
                        report_mismatch($sformatf("value %h, expected %h", value, want));
                end
            end
            if (start && !busy)
                expected_values.push_back(series_sum(mode, angle));
        end
    end
endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Drives angle/mode transactions into the sine/cosine unit: a directed set
// of extremes and landmarks, then random angles with random idle cycles.
// The checker predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module tb;

    localparam int RANDOM_ITEMS = 600;
    localparam int CYCLE_LIMIT  = 100000;
    localparam int DRAIN_CYCLES = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic mode = tsc_pkg::MODE_COS;
    logic signed [tsc_pkg::ANGLE_W-1:0] angle = '0;
    logic busy;
    logic done;
    logic signed [tsc_pkg::VALUE_W-1:0] value;
    int fail_count;
    int pending;
    int cycles = 0;

    always #1 clk = ~clk;

    taylor_sine_cosine_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .angle(angle), .done(done), .value(value)
    );

    tsc_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .mode(mode), .angle(angle), .done(done), .value(value),
        .fail_count(fail_count), .pending(pending)
    );

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // One transaction, with optional idle cycles ahead of it.
    task automatic send_angle(logic md, logic signed [tsc_pkg::ANGLE_W-1:0] x,
                              bit allow_idle);
        int gap;
        begin
            gap = 0;
            if (allow_idle && $urandom_range(99) < 13)
                gap = $urandom_range(1, 4);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            start <= 1'b1;
            mode  <= md;
            angle <= x;
            @(posedge clk);
            while (busy)
                @(posedge clk);
        end
    endtask

    initial
    begin
        logic signed [tsc_pkg::ANGLE_W-1:0] directed[];
        logic signed [tsc_pkg::ANGLE_W-1:0] x;

        directed = '{
            32'sh0000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
            32'sh8000_0001, 32'sh1921_FB54, -32'sh1921_FB54, 32'sh3243_F6A9,
            -32'sh3243_F6A9, 32'sh0000_0001, -32'sh0000_0001, 32'sh1000_0000,
            32'sh7FFF_FFFF
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes, small angles and quarter/half turns in both modes.
        foreach (directed[i])
        begin
            send_angle(tsc_pkg::MODE_COS, directed[i], 1'b0);
            send_angle(tsc_pkg::MODE_SIN, directed[i], 1'b0);
        end

        // Random angles: mostly in the nominal range, some anywhere.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(99) < 80)
                x = $signed($urandom_range(32'h1000_0000)) - 32'sh0800_0000
                    + $signed($urandom_range(32'h1000_0000)) - 32'sh0800_0000;
            else
                x = $urandom;
            send_angle(1'($urandom), x, !(n >= 200 && n < 300));
        end
        start <= 1'b0;

        // Let the pipeline drain, then allow for stray strobes.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
